// ===== rtl/cbpe_pkg.sv =====
package cbpe_pkg;

	localparam int COORD_W  = 32;
	localparam int T_FRAC   = 16;
	localparam int T_W      = T_FRAC + 1;
	localparam int ACC_W    = 40;
	localparam int PROD_W   = ACC_W + T_W + 1;
	localparam int NUM_REGS = 8;
	localparam int ADDR_W   = 5;
	localparam int IDX_W    = 3;
	localparam int NUM_CELLS = 3;
	localparam int NUM_LANES = 4;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic [T_W-1:0]            tparam_t;
	typedef logic [IDX_W-1:0]          reg_idx_t;

	localparam reg_idx_t REG_P0_X = 3'd0;
	localparam reg_idx_t REG_P0_Y = 3'd1;
	localparam reg_idx_t REG_P1_X = 3'd2;
	localparam reg_idx_t REG_P1_Y = 3'd3;
	localparam reg_idx_t REG_P2_X = 3'd4;
	localparam reg_idx_t REG_P2_Y = 3'd5;
	localparam reg_idx_t REG_P3_X = 3'd6;
	localparam reg_idx_t REG_P3_Y = 3'd7;

	localparam tparam_t T_ONE = tparam_t'(1) << T_FRAC;

	// power-basis coefficients of one axis, plus the scaled tangent terms
	typedef struct packed {
		acc_t a;
		acc_t b;
		acc_t c;
		acc_t d;
		acc_t a3;
		acc_t b2;
	} axis_coef_t;

endpackage

// ===== rtl/cubic_bezier_point_evaluator.sv =====
// Cubic Bezier point and tangent evaluator. Write the four control points over
// the APB port, then pulse start with param_t (Q1.16, values above 1.0 clamp to
// 1.0). One t is taken every cycle; busy never rises. Each beat comes back on
// done after passing through the input register, three Horner cells of two
// stages each (multiply, then round and add) per output, and the saturation
// register. The receiver cannot stall: results are shown for one cycle only.
// The first beat after a register write must start no earlier than the cycle
// after that write.
module cubic_bezier_point_evaluator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cbpe_pkg::ADDR_W-1:0]   paddr,
	input  logic [cbpe_pkg::COORD_W-1:0]  pwdata,
	output logic [cbpe_pkg::COORD_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [cbpe_pkg::T_W-1:0]      param_t,
	output logic                          done,
	output logic signed [cbpe_pkg::COORD_W-1:0] point_x,
	output logic signed [cbpe_pkg::COORD_W-1:0] point_y,
	output logic signed [cbpe_pkg::COORD_W-1:0] tangent_x,
	output logic signed [cbpe_pkg::COORD_W-1:0] tangent_y,
	output logic                          clipped
);
	import cbpe_pkg::*;

	localparam acc_t SAT_MAX = acc_t'({1'b0, {(COORD_W-1){1'b1}}});
	localparam acc_t SAT_MIN = ~SAT_MAX;

	axis_coef_t coef_x;
	axis_coef_t coef_y;
	logic       valid_s0;
	tparam_t    t_s0;

	acc_t    lane_init [NUM_LANES];
	acc_t    lane_add  [NUM_LANES][NUM_CELLS];
	logic    ch_valid  [NUM_LANES][NUM_CELLS+1];
	acc_t    ch_acc    [NUM_LANES][NUM_CELLS+1];
	tparam_t ch_t      [NUM_LANES][NUM_CELLS+1];

	coord_t  sat_val [NUM_LANES];
	logic    sat_hit [NUM_LANES];
	coord_t  res_q   [NUM_LANES];
	logic    clip_q;
	logic    done_q;
	logic    all_valid;

	cbpe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.coef_x  (coef_x),
		.coef_y  (coef_y)
	);

	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= start;
		end
	end

	always_ff @(posedge clk) begin
		t_s0 <= (param_t > T_ONE) ? T_ONE : param_t;
	end

	// lanes: point x, point y, tangent x, tangent y
	always_comb begin
		lane_init[0]   = coef_x.a;
		lane_add[0][0] = coef_x.b;
		lane_add[0][1] = coef_x.c;
		lane_add[0][2] = coef_x.d;
		lane_init[1]   = coef_y.a;
		lane_add[1][0] = coef_y.b;
		lane_add[1][1] = coef_y.c;
		lane_add[1][2] = coef_y.d;
		lane_init[2]   = '0;
		lane_add[2][0] = coef_x.a3;
		lane_add[2][1] = coef_x.b2;
		lane_add[2][2] = coef_x.c;
		lane_init[3]   = '0;
		lane_add[3][0] = coef_y.a3;
		lane_add[3][1] = coef_y.b2;
		lane_add[3][2] = coef_y.c;
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		assign ch_valid[l][0] = valid_s0;
		assign ch_acc[l][0]   = lane_init[l];
		assign ch_t[l][0]     = t_s0;
		for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
			cbpe_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (ch_valid[l][k]),
				.acc       (ch_acc[l][k]),
				.t         (ch_t[l][k]),
				.addend    (lane_add[l][k]),
				.out_valid (ch_valid[l][k+1]),
				.acc_out   (ch_acc[l][k+1]),
				.t_out     (ch_t[l][k+1])
			);
		end
	end

	always_comb begin
		all_valid = 1'b1;
		for (int l = 0; l < NUM_LANES; l++) begin
			all_valid = all_valid & ch_valid[l][NUM_CELLS];
			if (ch_acc[l][NUM_CELLS] > SAT_MAX) begin
				sat_val[l] = coord_t'(SAT_MAX[COORD_W-1:0]);
				sat_hit[l] = 1'b1;
			end else if (ch_acc[l][NUM_CELLS] < SAT_MIN) begin
				sat_val[l] = coord_t'(SAT_MIN[COORD_W-1:0]);
				sat_hit[l] = 1'b1;
			end else begin
				sat_val[l] = coord_t'(ch_acc[l][NUM_CELLS][COORD_W-1:0]);
				sat_hit[l] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= all_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < NUM_LANES; l++) begin
			res_q[l] <= sat_val[l];
		end
		clip_q <= sat_hit[0] | sat_hit[1] | sat_hit[2] | sat_hit[3];
	end

	assign done      = done_q;
	assign point_x   = res_q[0];
	assign point_y   = res_q[1];
	assign tangent_x = res_q[2];
	assign tangent_y = res_q[3];
	assign clipped   = clip_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 8))
		else $error("result beat without a start 8 cycles earlier");

	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##7 done)
		else $error("start beat lost in pipeline");

	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped) |-> (
			point_x == coord_t'(SAT_MAX[COORD_W-1:0]) ||
			point_x == coord_t'(SAT_MIN[COORD_W-1:0]) ||
			point_y == coord_t'(SAT_MAX[COORD_W-1:0]) ||
			point_y == coord_t'(SAT_MIN[COORD_W-1:0]) ||
			tangent_x == coord_t'(SAT_MAX[COORD_W-1:0]) ||
			tangent_x == coord_t'(SAT_MIN[COORD_W-1:0]) ||
			tangent_y == coord_t'(SAT_MAX[COORD_W-1:0]) ||
			tangent_y == coord_t'(SAT_MIN[COORD_W-1:0])))
		else $error("clip flag set with no value on a rail");

endmodule

// ===== rtl/cbpe_cell.sv =====
module cbpe_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  cbpe_pkg::acc_t   acc,
	input  cbpe_pkg::tparam_t t,
	input  cbpe_pkg::acc_t   addend,
	output logic             out_valid,
	output cbpe_pkg::acc_t   acc_out,
	output cbpe_pkg::tparam_t t_out
);
	import cbpe_pkg::*;

	localparam prod_t HALF    = prod_t'(1) <<< (T_FRAC - 1);
	localparam prod_t HALF_M1 = HALF - prod_t'(1);

	logic    valid_s1;
	prod_t   prod_s1;
	tparam_t t_s1;
	logic    valid_s2;
	acc_t    acc_s2;
	tparam_t t_s2;
	prod_t   rnd;
	prod_t   shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= acc * $signed({1'b0, t});
		t_s1    <= t;
	end

	// round to nearest, ties away from zero
	always_comb begin
		rnd     = prod_s1 + (prod_s1[PROD_W-1] ? HALF_M1 : HALF);
		shifted = rnd >>> T_FRAC;
	end

	always_ff @(posedge clk) begin
		acc_s2 <= $signed(shifted[ACC_W-1:0]) + addend;
		t_s2   <= t_s1;
	end

	assign out_valid = valid_s2;
	assign acc_out   = acc_s2;
	assign t_out     = t_s2;

	a_valid_lat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(in_valid, 2))
		else $error("cell output beat without input beat");

	a_t_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && t == '0) |=> ##1 (acc_out == $past(addend)))
		else $error("t of zero must give the addend");

	a_t_one: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && t == T_ONE) |=> ##1 (acc_out == $past(acc, 2) + $past(addend)))
		else $error("t of one must give acc plus addend");

endmodule

// ===== rtl/cbpe_regs.sv =====
module cbpe_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cbpe_pkg::ADDR_W-1:0]   paddr,
	input  logic [cbpe_pkg::COORD_W-1:0]  pwdata,
	output logic [cbpe_pkg::COORD_W-1:0]  prdata,
	output cbpe_pkg::axis_coef_t          coef_x,
	output cbpe_pkg::axis_coef_t          coef_y
);
	import cbpe_pkg::*;

	coord_t     regs_q [NUM_REGS];
	axis_coef_t coef_x_q;
	axis_coef_t coef_y_q;
	reg_idx_t   idx;
	logic       wr_en;

	function automatic axis_coef_t make_coef(coord_t q0, coord_t q1, coord_t q2, coord_t q3);
		acc_t e0;
		acc_t e1;
		acc_t e2;
		acc_t e3;
		axis_coef_t r;
		e0 = acc_t'(q0);
		e1 = acc_t'(q1);
		e2 = acc_t'(q2);
		e3 = acc_t'(q3);
		r.a  = -e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3;
		r.b  = (e0 <<< 1) + e0 - (e1 <<< 2) - (e1 <<< 1) + (e2 <<< 1) + e2;
		r.c  = (e1 <<< 1) + e1 - (e0 <<< 1) - e0;
		r.d  = e0;
		r.a3 = (r.a <<< 1) + r.a;
		r.b2 = r.b <<< 1;
		return r;
	endfunction

	assign idx   = paddr[ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (wr_en) begin
			regs_q[idx] <= coord_t'(pwdata);
		end
	end

	always_ff @(posedge clk) begin
		coef_x_q <= make_coef(regs_q[REG_P0_X], regs_q[REG_P1_X],
			regs_q[REG_P2_X], regs_q[REG_P3_X]);
		coef_y_q <= make_coef(regs_q[REG_P0_Y], regs_q[REG_P1_Y],
			regs_q[REG_P2_Y], regs_q[REG_P3_Y]);
	end

	assign prdata = regs_q[idx];
	assign coef_x = coef_x_q;
	assign coef_y = coef_y_q;

endmodule
